/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro expects clk, and ASSERT_CLK also rst_n, to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that must also hold during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/idcv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idcv_pkg
// Types, codes and small arithmetic helpers for the identity-number
// check-digit validator.
// ----------------------------------------------------------------------------
package idcv_pkg;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NONDIGIT = 3'd1;
    localparam logic [2:0] ERR_LENGTH   = 3'd2;
    localparam logic [2:0] ERR_PROVINCE = 3'd3;
    localparam logic [2:0] ERR_THIRD    = 3'd4;
    localparam logic [2:0] ERR_CHECK    = 3'd5;
    localparam logic [2:0] ERR_SUFFIX   = 3'd6;

    localparam logic [1:0] KIND_PERSON  = 2'd0;
    localparam logic [1:0] KIND_PUBLIC  = 2'd1;
    localparam logic [1:0] KIND_PRIVATE = 2'd2;

    localparam logic [3:0] LEN_PERSONAL = 4'd10;
    localparam logic [3:0] LEN_TAXPAYER = 4'd13;
    localparam logic [3:0] POS_SAT      = 4'd14;
    localparam logic [6:0] PROV_MAX     = 7'd23;
    localparam logic [3:0] THIRD_MAX    = 4'd5;
    localparam logic [3:0] THIRD_PUBLIC = 4'd6;
    localparam logic [3:0] THIRD_PRIV   = 4'd9;
    localparam logic [3:0] SUFFIX_MAX   = 4'd3;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // Running state of one number. Weighted sums are kept as residues
    // (mod 10 / mod 11), which is all the final checks need.
    typedef struct packed {
        logic [3:0] position;
        logic       saw_nondigit;
        logic [3:0] dbl_mod10;
        logic [3:0] pub_mod11;
        logic [3:0] priv_mod11;
        logic [6:0] province;
        logic [3:0] third;
        logic [3:0] ninth;
        logic [3:0] tenth;
        logic       suffix_big;
    } acc_t;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] error_code;
        logic [1:0] entity_kind;
    } res_t;

    function automatic logic [2:0] pub_weight(input logic [3:0] p);
        logic [2:0] w;
        unique case (p)
            4'd0:    w = 3'd3;
            4'd1:    w = 3'd2;
            4'd2:    w = 3'd7;
            4'd3:    w = 3'd6;
            4'd4:    w = 3'd5;
            4'd5:    w = 3'd4;
            4'd6:    w = 3'd3;
            4'd7:    w = 3'd2;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] priv_weight(input logic [3:0] p);
        logic [2:0] w;
        unique case (p)
            4'd0:    w = 3'd4;
            4'd1:    w = 3'd3;
            4'd2:    w = 3'd2;
            4'd3:    w = 3'd7;
            4'd4:    w = 3'd6;
            4'd5:    w = 3'd5;
            4'd6:    w = 3'd4;
            4'd7:    w = 3'd3;
            4'd8:    w = 3'd2;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

    // Reduce a value below 88 modulo 11 by three compare-and-subtract steps.
    function automatic logic [3:0] fold_mod11(input logic [6:0] v);
        logic [6:0] t;
        t = v;
        if (t >= 7'd44) t = t - 7'd44;
        if (t >= 7'd22) t = t - 7'd22;
        if (t >= 7'd11) t = t - 7'd11;
        return t[3:0];
    endfunction

    // Mod-11 check: remainder 0 expects 0, otherwise 11 - remainder.
    function automatic logic mod11_ok(input logic [3:0] r, input logic [3:0] d);
        logic [4:0] s;
        s = {1'b0, r} + {1'b0, d};
        return ((r == 4'd0) && (d == 4'd0)) || (s == 5'd11);
    endfunction

    function automatic logic mod10_ok(input logic [3:0] r, input logic [3:0] d);
        logic [4:0] s;
        s = {1'b0, r} + {1'b0, d};
        return ((r == 4'd0) && (d == 4'd0)) || (s == 5'd10);
    endfunction

endpackage

/* rtl/id_number_check_digit_validator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_number_check_digit_validator_core
// Validates identity numbers streamed one character per transfer and
// returns one verdict per number on the closing character.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                               Handshake
//  s_*       in   tdata[7:0] character, tlast last_char  tvalid/tready
//  m_*       out  tdata[0] valid_res, [3:1] error_code,  tvalid/tready
//                 tuser[1:0] entity_kind
//  cfg_*     in   cfg_wdata taxpayer_mode                 cfg_we, no wait
//
//  One character per cycle sustained while no closing character waits for the
//  result slot; a verdict is judged out of the input register, then held in the
//  result register and offered from there.
//  rst_n clears the running state, the mode register and both valid flags.
//  A stalled result holds the closing character in the input register;
//  characters that close no number keep flowing while a result waits.
// ----------------------------------------------------------------------------
module id_number_check_digit_validator_core
    import idcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,    // taxpayer_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] character
    input  logic       s_tlast,      // last_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [0] valid_res, [3:1] error_code, [7:4] zero
    output logic [1:0] m_tuser       // [1:0] entity_kind
);

    logic       mode_reg;
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    acc_t       acc_reg;
    acc_t       acc_next;
    acc_t       acc_upd;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       out_res_reg;
    res_t       verdict;
    logic       out_free;
    logic       consume;
    logic       accept;

    // Fold the held character into the running state.
    idcv_digit_acc u_acc (
        .acc       (acc_reg),
        .character (in_char_reg),
        .acc_upd   (acc_upd)
    );

    // Judge on the state that already includes the closing character.
    idcv_judge u_judge (
        .acc           (acc_upd),
        .taxpayer_mode (mode_reg),
        .res           (verdict)
    );

    // A closing character may only advance when the result slot frees up.
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || consume;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (consume)
        begin
            // Drop the state after a verdict so the next number starts clean.
            acc_next = in_last_reg ? '0 : acc_upd;
            if (in_last_reg)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    // Payload registers: hold unless a transfer or a verdict loads them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (consume && in_last_reg)
        begin
            out_res_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.error_code, out_res_reg.valid_res};
    assign m_tuser  = out_res_reg.entity_kind;

endmodule

/* rtl/idcv_digit_acc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idcv_digit_acc
// Folds one character into the running state of the current number.
// ----------------------------------------------------------------------------
module idcv_digit_acc
    import idcv_pkg::*;
(
    input  acc_t       acc,
    input  logic [7:0] character,
    output acc_t       acc_upd
);

    logic       is_digit;
    logic [7:0] diff;
    logic [3:0] d;
    logic [3:0] p;
    logic [4:0] twice;
    logic [3:0] dbl_term;
    logic [4:0] dbl_sum;
    logic [6:0] pub_prod;
    logic [6:0] priv_prod;
    logic [6:0] prov_tens;

    assign is_digit  = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign diff      = character - CHAR_ZERO;
    assign d         = is_digit ? diff[3:0] : 4'd0;
    assign p         = acc.position;
    assign twice     = {d, 1'b0};
    assign pub_prod  = 7'(d) * 7'(pub_weight(p));
    assign priv_prod = 7'(d) * 7'(priv_weight(p));
    assign prov_tens = {d, 3'b000} + {2'b00, d, 1'b0};

    always_comb
    begin
        // Double on even positions, folding two-digit results.
        if (p[0] == 1'b0)
        begin
            dbl_term = (twice >= 5'd10) ? 4'(twice - 5'd9) : twice[3:0];
        end
        else
        begin
            dbl_term = d;
        end
        dbl_sum = {1'b0, acc.dbl_mod10} + {1'b0, dbl_term};

        acc_upd = acc;
        if (!is_digit)
        begin
            acc_upd.saw_nondigit = 1'b1;
        end
        if (p < POS_SAT)
        begin
            acc_upd.position = p + 4'd1;
            if (p == 4'd0) acc_upd.province = prov_tens;
            if (p == 4'd1) acc_upd.province = acc.province + {3'b000, d};
            if (p == 4'd2) acc_upd.third = d;
            if (p == 4'd8) acc_upd.ninth = d;
            if (p == 4'd9) acc_upd.tenth = d;
            if (p <= 4'd8)
            begin
                acc_upd.dbl_mod10  = (dbl_sum >= 5'd10) ? 4'(dbl_sum - 5'd10)
                                                         : dbl_sum[3:0];
                acc_upd.priv_mod11 = fold_mod11({3'b000, acc.priv_mod11} + priv_prod);
            end
            if (p <= 4'd7)
            begin
                acc_upd.pub_mod11 = fold_mod11({3'b000, acc.pub_mod11} + pub_prod);
            end
            // Suffix above three: any non-zero leading digit or a last digit above three.
            if (((p == 4'd10) || (p == 4'd11)) && (d != 4'd0))
            begin
                acc_upd.suffix_big = 1'b1;
            end
            if ((p == 4'd12) && (d > SUFFIX_MAX))
            begin
                acc_upd.suffix_big = 1'b1;
            end
        end
    end

endmodule

/* rtl/idcv_judge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idcv_judge
// Applies the checks to a finished number and picks the first failing one.
// ----------------------------------------------------------------------------
module idcv_judge
    import idcv_pkg::*;
(
    input  acc_t acc,
    input  logic taxpayer_mode,
    output res_t res
);

    logic [3:0] want_len;
    logic [1:0] kind;
    logic [2:0] err;
    logic       prov_bad;

    assign want_len = taxpayer_mode ? LEN_TAXPAYER : LEN_PERSONAL;
    assign prov_bad = (acc.province == 7'd0) || (acc.province > PROV_MAX);

    always_comb
    begin
        kind = KIND_PERSON;
        if (taxpayer_mode && (acc.third == THIRD_PUBLIC)) kind = KIND_PUBLIC;
        if (taxpayer_mode && (acc.third == THIRD_PRIV))   kind = KIND_PRIVATE;

        priority if (acc.saw_nondigit)
        begin
            err = ERR_NONDIGIT;
        end
        else if (acc.position != want_len)
        begin
            err = ERR_LENGTH;
        end
        else if (prov_bad)
        begin
            err = ERR_PROVINCE;
        end
        else if ((kind == KIND_PUBLIC) && !mod11_ok(acc.pub_mod11, acc.ninth))
        begin
            err = ERR_CHECK;
        end
        else if ((kind == KIND_PRIVATE) && !mod11_ok(acc.priv_mod11, acc.tenth))
        begin
            err = ERR_CHECK;
        end
        else if ((kind == KIND_PERSON) && (acc.third > THIRD_MAX))
        begin
            err = ERR_THIRD;
        end
        else if ((kind == KIND_PERSON) && !mod10_ok(acc.dbl_mod10, acc.tenth))
        begin
            err = ERR_CHECK;
        end
        else if (taxpayer_mode && acc.suffix_big)
        begin
            err = ERR_SUFFIX;
        end
        else
        begin
            err = ERR_NONE;
        end

        res.valid_res   = (err == ERR_NONE);
        res.error_code  = err;
        res.entity_kind = ((err == ERR_NONDIGIT) || (err == ERR_LENGTH)) ? KIND_PERSON : kind;
    end

endmodule

/* rtl/idcv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idcv_checker
// Port-level checks on the validator's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module idcv_checker
    import idcv_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    `ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !m_tvalid, "result offered during reset")

    `ASSERT_CLK(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `ASSERT_CLK(a_valid_matches_code, m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == ERR_NONE)), "valid flag disagrees with error code")

    `ASSERT_CLK(a_kind_cleared_early, m_tvalid && (m_tdata[3:1] == ERR_NONDIGIT || m_tdata[3:1] == ERR_LENGTH) |-> m_tuser == KIND_PERSON, "entity kind set on early error")

endmodule

bind id_number_check_digit_validator_core idcv_checker u_idcv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
